/* hw/rtl/iap_pkg.sv */
`timescale 1ns / 1ps

package iap_pkg;

  // Item mode codes.
  localparam logic [1:0] MODE_LOAD_ABOVE = 2'd0;
  localparam logic [1:0] MODE_LOAD_LEFT  = 2'd1;
  localparam logic [1:0] MODE_PREDICT    = 2'd2;

  localparam int LOG2_MIN        = 2;
  localparam int LOG2_MAX        = 5;
  localparam int DIR_MIN         = 2;
  localparam int DIR_MAX         = 34;
  localparam int DIR_VER_MIN     = 18;
  localparam int DIR_VER_CENTER  = 26;
  localparam int DIR_HOR_CENTER  = 10;
  localparam int BD_MIN          = 8;
  localparam int BD_MAX          = 12;
  localparam int BD_RESET        = 8;
  localparam int INV_ROUND       = 128;
  localparam int INTERP_ROUND    = 16;
  // Signed width of a main reference index before it is resolved.
  localparam int IDX_W           = 9;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  ref_index;
    logic [11:0] ref_sample;
    logic [2:0]  block_log2;
    logic [5:0]  pred_dir;
    logic        edge_filter;
    logic [4:0]  row;
  } item_t;

  typedef struct packed {
    logic [11:0] sample;
    logic [4:0]  column;
    logic [4:0]  out_row;
    logic        last;
  } result_t;

  // Decoded row request handed to the address generator.
  typedef struct packed {
    logic        ver;
    logic [6:0]  angle;
    logic [12:0] inv;
    logic        filt;
    logic [4:0]  n_m1;
    logic [4:0]  row;
  } pred_cmd_t;

  // Where the two operands of one sample come from.
  typedef struct packed {
    logic x_left;
    logic y_left;
    logic x_zero;
    logic y_zero;
  } ref_sel_t;

  typedef struct packed {
    logic [4:0] fr;
    logic       filt_now;
    logic [4:0] column;
    logic [4:0] out_row;
    logic       last;
  } samp_tag_t;

  typedef struct packed {
    logic [11:0] above0;
    logic [11:0] above1;
    logic [11:0] left0;
    logic [11:0] left1;
  } ref_rd_t;

  function automatic logic [5:0] ang_step(input logic [3:0] a);
    logic [5:0] r;
    case (a)
      4'd0:    r = 6'd0;
      4'd1:    r = 6'd2;
      4'd2:    r = 6'd5;
      4'd3:    r = 6'd9;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd17;
      4'd6:    r = 6'd21;
      4'd7:    r = 6'd26;
      4'd8:    r = 6'd32;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] inv_step(input logic [3:0] a);
    logic [12:0] r;
    case (a)
      4'd0:    r = 13'd0;
      4'd1:    r = 13'd4096;
      4'd2:    r = 13'd1638;
      4'd3:    r = 13'd910;
      4'd4:    r = 13'd630;
      4'd5:    r = 13'd482;
      4'd6:    r = 13'd390;
      4'd7:    r = 13'd315;
      4'd8:    r = 13'd256;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/iap_ref_store.sv */
`timescale 1ns / 1ps

module iap_ref_store #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               wr_left,
  input  logic [AW-1:0]      wr_addr,
  input  logic [11:0]        wr_data,
  input  logic               rd_en,
  input  logic               x_left,
  input  logic [AW-1:0]      x_addr,
  input  logic [AW-1:0]      y_addr,
  output iap_pkg::ref_rd_t   rd
);

  logic [11:0] above_mem [DEPTH];
  logic [11:0] left_mem  [DEPTH];
  logic [AW-1:0] above_a0;
  logic [AW-1:0] left_a0;

  // Port 0 of the store holding the first operand reads it; port 0 of the
  // other store reads the corner, which the edge filter needs.
  assign above_a0 = x_left ? '0 : x_addr;
  assign left_a0  = x_left ? x_addr : '0;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_left) begin
      above_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_left) begin
      left_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd.above0 <= above_mem[above_a0];
      rd.above1 <= above_mem[y_addr];
      rd.left0  <= left_mem[left_a0];
      rd.left1  <= left_mem[y_addr];
    end
  end

endmodule

/* hw/rtl/iap_addr_gen.sv */
`timescale 1ns / 1ps

module iap_addr_gen #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  iap_pkg::pred_cmd_t    cmd,
  input  logic                  advance,
  output logic                  idle,
  output logic                  b_valid,
  output logic [AW-1:0]         x_addr,
  output logic [AW-1:0]         y_addr,
  output iap_pkg::ref_sel_t     sel,
  output iap_pkg::samp_tag_t    tag
);

  localparam logic signed [iap_pkg::IDX_W-1:0] DEPTH_S = iap_pkg::IDX_W'(DEPTH);

  typedef struct packed {
    logic          side;
    logic          zero;
    logic [AW-1:0] addr;
  } ref_loc_t;

  iap_pkg::pred_cmd_t cmd_q;
  logic               busy;
  logic [4:0]         col;

  logic [4:0]         k;
  logic [4:0]         l;
  logic [5:0]         kp1;
  logic signed [13:0] pos_next;

  logic               a_valid;
  logic signed [13:0] a_pos;
  logic [5:0]         a_lp1;
  logic [5:0]         a_kp1;
  logic               a_ver;
  logic               a_filt_now;
  logic [12:0]        a_inv;
  logic [4:0]         a_col;
  logic [4:0]         a_row;
  logic               a_last;

  logic signed [iap_pkg::IDX_W-1:0] ip;
  logic signed [iap_pkg::IDX_W-1:0] i0;
  logic signed [iap_pkg::IDX_W-1:0] i1;
  ref_loc_t           x_loc;
  ref_loc_t           y_main;
  ref_loc_t           y_loc;

  // A negative main index is projected onto the side store through the
  // inverse angle; anything past the end of a store reads as zero.
  function automatic ref_loc_t locate(input logic signed [iap_pkg::IDX_W-1:0] idx,
                                      input logic [12:0] inv);
    logic [5:0]  mag;
    logic [18:0] prod;
    logic [10:0] sidx;
    ref_loc_t    loc;
    mag  = 6'(-idx);
    prod = 19'(mag) * 19'(inv);
    sidx = 11'((prod + 19'(iap_pkg::INV_ROUND)) >> 8);
    if (idx[iap_pkg::IDX_W-1]) begin
      loc.side = 1'b1;
      loc.zero = (sidx >= 11'(DEPTH));
      loc.addr = AW'(sidx);
    end else begin
      loc.side = 1'b0;
      loc.zero = (idx >= DEPTH_S);
      loc.addr = AW'(idx);
    end
    return loc;
  endfunction

  assign idle = !busy && !a_valid && !b_valid;

  // Sequencer: one column per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (advance && busy && (col == cmd_q.n_m1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
      col   <= '0;
    end else if (advance && busy) begin
      col <= col + 5'd1;
    end
  end

  // Stage A: projection offset of this column.
  assign k        = cmd_q.ver ? cmd_q.row : col;
  assign l        = cmd_q.ver ? col : cmd_q.row;
  assign kp1      = {1'b0, k} + 6'd1;
  assign pos_next = $signed({1'b0, kp1}) * $signed(cmd_q.angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= busy;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pos      <= pos_next;
      a_lp1      <= {1'b0, l} + 6'd1;
      a_kp1      <= kp1;
      a_ver      <= cmd_q.ver;
      a_filt_now <= cmd_q.filt && (l == 5'd0);
      a_inv      <= cmd_q.inv;
      a_col      <= col;
      a_row      <= cmd_q.row;
      a_last     <= (col == cmd_q.n_m1);
    end
  end

  // Stage B: resolve the two operand positions to store addresses.
  assign ip     = iap_pkg::IDX_W'(a_pos >>> 5);
  assign i0     = $signed({3'b000, a_lp1}) + ip;
  assign i1     = i0 + 9'sd1;
  assign x_loc  = locate(i0, a_inv);
  assign y_main = locate(i1, a_inv);

  always_comb begin
    y_loc = y_main;
    if (a_filt_now) begin
      y_loc.side = 1'b1;
      y_loc.zero = 1'b0;
      y_loc.addr = AW'(a_kp1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_addr       <= x_loc.addr;
      y_addr       <= y_loc.addr;
      sel.x_left   <= !(x_loc.side ^ a_ver);
      sel.y_left   <= !(y_loc.side ^ a_ver);
      sel.x_zero   <= x_loc.zero;
      sel.y_zero   <= y_loc.zero;
      tag.fr       <= a_pos[4:0];
      tag.filt_now <= a_filt_now;
      tag.column   <= a_col;
      tag.out_row  <= a_row;
      tag.last     <= a_last;
    end
  end

endmodule

/* hw/rtl/iap_sample_calc.sv */
`timescale 1ns / 1ps

module iap_sample_calc (
  input  iap_pkg::ref_rd_t   rd,
  input  iap_pkg::ref_sel_t  sel,
  input  iap_pkg::samp_tag_t tag,
  input  logic [3:0]         sample_bits,
  output logic [11:0]        sample
);

  logic [11:0]        x;
  logic [11:0]        y;
  logic [11:0]        z;
  logic [3:0]         bd_sat;
  logic [11:0]        maxv;
  logic signed [12:0] diff;
  logic signed [12:0] half;
  logic signed [13:0] sum;
  logic [5:0]         w0;
  logic [18:0]        acc;

  assign x = sel.x_zero ? 12'd0 : (sel.x_left ? rd.left0 : rd.above0);
  assign y = sel.y_zero ? 12'd0 : (sel.y_left ? rd.left1 : rd.above1);
  // The corner of the side store sits on the port 0 that x does not use.
  assign z = sel.x_left ? rd.above0 : rd.left0;

  always_comb begin
    if (sample_bits < 4'(iap_pkg::BD_MIN)) begin
      bd_sat = 4'(iap_pkg::BD_MIN);
    end else if (sample_bits > 4'(iap_pkg::BD_MAX)) begin
      bd_sat = 4'(iap_pkg::BD_MAX);
    end else begin
      bd_sat = sample_bits;
    end
  end

  assign maxv = 12'((13'd1 << bd_sat) - 13'd1);

  // Edge filter: add half the side gradient, rounded toward minus infinity.
  assign diff = $signed({1'b0, y}) - $signed({1'b0, z});
  assign half = diff >>> 1;
  assign sum  = $signed({2'b00, x}) + 14'(half);

  assign w0  = 6'd32 - {1'b0, tag.fr};
  assign acc = 19'(w0) * 19'(x) + 19'(tag.fr) * 19'(y) + 19'(iap_pkg::INTERP_ROUND);

  always_comb begin
    if (tag.filt_now) begin
      if (sum[13]) begin
        sample = 12'd0;
      end else if (sum[12:0] > {1'b0, maxv}) begin
        sample = maxv;
      end else begin
        sample = sum[11:0];
      end
    end else if (tag.fr != 5'd0) begin
      sample = 12'(acc >> 5);
    end else begin
      sample = x;
    end
  end

endmodule

/* hw/rtl/intra_angular_predictor_unit.sv */
`timescale 1ns / 1ps

// Angular intra predictor for directions 2 to 34.
// The item channel carries three kinds of transfers: loads of the above or
// left reference store (index 0 is the corner) and row requests. A load
// returns nothing. A row request for an N x N block
// returns N result transfers, one sample per column, with last set on the
// final column; rows at or beyond N return nothing. Horizontal directions
// return the transposed block.
// Each sample passes the stage A and stage B address registers, the registered
// store read and the output register; samples follow one per cycle while the
// receiver keeps up, since each column needs one read of both reference
// memories. No new item is taken until the address generator has issued every column.
// When the receiver stalls the whole sample pipeline holds in place; the
// output register keeps its result until it is taken.
// The cfg channel sets the bit depth for the edge filter clip; it is always
// ready and should be written while no row is in flight. Reset clears the
// control state and sets the bit depth to 8; the reference stores keep
// no reset value and must be loaded before use.
module intra_angular_predictor_unit #(
  parameter int MAX_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  iap_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output iap_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);

  localparam int DEPTH = 2 * MAX_SIZE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CAP   = (MAX_SIZE < 32) ? MAX_SIZE : 32;

  logic               accept;
  logic               advance;
  logic [3:0]         sample_bits;

  logic [2:0]         lg_sat;
  logic [5:0]         n_full;
  logic [5:0]         n;
  logic [5:0]         dir_sat;
  logic               ver;
  logic [6:0]         ang_raw;
  logic [3:0]         absi;
  logic [5:0]         ang_mag;
  iap_pkg::pred_cmd_t cmd;
  logic               start;
  logic               wr_en;

  logic               gen_idle;
  logic               b_valid;
  logic [AW-1:0]      x_addr;
  logic [AW-1:0]      y_addr;
  iap_pkg::ref_sel_t  b_sel;
  iap_pkg::samp_tag_t b_tag;
  iap_pkg::ref_rd_t   rd;

  logic               c_valid;
  iap_pkg::ref_sel_t  c_sel;
  iap_pkg::samp_tag_t c_tag;
  logic [11:0]        sample;

  assign item_ready = gen_idle;
  assign accept     = item_valid && item_ready;
  assign advance    = !result_valid || result_ready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bits <= 4'(iap_pkg::BD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      sample_bits <= cfg_data;
    end
  end

  // Decode a row request.
  always_comb begin
    if (item.block_log2 < 3'(iap_pkg::LOG2_MIN)) begin
      lg_sat = 3'(iap_pkg::LOG2_MIN);
    end else if (item.block_log2 > 3'(iap_pkg::LOG2_MAX)) begin
      lg_sat = 3'(iap_pkg::LOG2_MAX);
    end else begin
      lg_sat = item.block_log2;
    end
    if (item.pred_dir < 6'(iap_pkg::DIR_MIN)) begin
      dir_sat = 6'(iap_pkg::DIR_MIN);
    end else if (item.pred_dir > 6'(iap_pkg::DIR_MAX)) begin
      dir_sat = 6'(iap_pkg::DIR_MAX);
    end else begin
      dir_sat = item.pred_dir;
    end
  end

  assign n_full  = 6'd1 << lg_sat;
  assign n       = (n_full > 6'(CAP)) ? 6'(CAP) : n_full;
  assign ver     = (dir_sat >= 6'(iap_pkg::DIR_VER_MIN));
  assign ang_raw = ver ? 7'({1'b0, dir_sat}) - 7'(iap_pkg::DIR_VER_CENTER)
                       : 7'(iap_pkg::DIR_HOR_CENTER) - 7'({1'b0, dir_sat});
  assign absi    = ang_raw[6] ? 4'(7'd0 - ang_raw) : 4'(ang_raw);
  assign ang_mag = iap_pkg::ang_step(absi);

  assign cmd.ver   = ver;
  assign cmd.angle = ang_raw[6] ? 7'd0 - {1'b0, ang_mag} : {1'b0, ang_mag};
  assign cmd.inv   = iap_pkg::inv_step(absi);
  assign cmd.filt  = item.edge_filter && (absi == 4'd0);
  assign cmd.n_m1  = 5'(n - 6'd1);
  assign cmd.row   = item.row;

  assign start = accept && (item.mode == iap_pkg::MODE_PREDICT) && ({1'b0, item.row} < n);
  assign wr_en = accept
               && (item.mode == iap_pkg::MODE_LOAD_ABOVE || item.mode == iap_pkg::MODE_LOAD_LEFT)
               && (8'(item.ref_index) < 8'(DEPTH));

  iap_addr_gen #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_addr_gen (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .advance (advance),
    .idle    (gen_idle),
    .b_valid (b_valid),
    .x_addr  (x_addr),
    .y_addr  (y_addr),
    .sel     (b_sel),
    .tag     (b_tag)
  );

  // Loads are taken only when no read is pending, so a read never sees a
  // store written after its request.
  iap_ref_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ref_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_left (item.mode == iap_pkg::MODE_LOAD_LEFT),
    .wr_addr (AW'(item.ref_index)),
    .wr_data (item.ref_sample),
    .rd_en   (advance && b_valid),
    .x_left  (b_sel.x_left),
    .x_addr  (x_addr),
    .y_addr  (y_addr),
    .rd      (rd)
  );

  iap_sample_calc u_sample_calc (
    .rd          (rd),
    .sel         (c_sel),
    .tag         (c_tag),
    .sample_bits (sample_bits),
    .sample      (sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      c_valid      <= b_valid;
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_sel          <= b_sel;
      c_tag          <= b_tag;
      result.sample  <= sample;
      result.column  <= c_tag.column;
      result.out_row <= c_tag.out_row;
      result.last    <= c_tag.last;
    end
  end

endmodule

/* hw/rtl/iap_checker.sv */
`timescale 1ns / 1ps

module iap_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input iap_pkg::result_t result
);

  // A stalled result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Within a row the columns come in order, one transfer after another.
  a_column_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.last |=>
      !result_valid || result.column == 5'($past(result.column) + 5'd1))
    else $error("column out of sequence");

  a_row_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.last |=>
      !result_valid || result.out_row == $past(result.out_row))
    else $error("row changed before the last sample");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.last |=>
      !result_valid || result.column == 5'd0)
    else $error("new row does not start at column zero");

endmodule

bind intra_angular_predictor_unit iap_checker u_iap_checker (.*);

/* tb/tb_intra_angular_predictor_unit.sv */
`timescale 1ns / 1ps

module tb_intra_angular_predictor_unit;

  localparam int CLK_PERIOD = 12;
  localparam int REF_DEPTH = 65;
  localparam int MAX_MISMATCH_LOG = 10;
  localparam longint TIMEOUT_NS = 64'd20_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Projection angle and inverse angle per absolute angle index.
  localparam int ANGLE_TABLE [0:8] = '{0, 2, 5, 9, 13, 17, 21, 26, 32};
  localparam int INV_TABLE [0:8] = '{0, 4096, 1638, 910, 630, 482, 390, 315, 256};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  iap_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  iap_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  // Mirror of the block state.
  logic [11:0] above_copy [0:REF_DEPTH-1];
  logic [11:0] left_copy [0:REF_DEPTH-1];
  int depth_reg = iap_pkg::BD_RESET;

  iap_pkg::result_t pending_samples [$];
  iap_pkg::result_t want;

  int mismatches = 0;
  int samples_checked = 0;
  int rows_sent = 0;
  int loads_done = 0;
  int depth_writes = 0;
  int items_sent = 0;
  int burst_left = 0;
  int ready_cycle = 0;
  int hold_cnt = 0;

  intra_angular_predictor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // The receiver cycles through open, random, periodic and long-hold stall styles.
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    case ((ready_cycle / 300) % 4)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 3) != 0);
      2: result_ready <= ((ready_cycle % 5) < 2);
      default: begin
        if (hold_cnt > 0) begin
          hold_cnt <= hold_cnt - 1;
          result_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          hold_cnt <= $urandom_range(1, 20);
          result_ready <= 1'b0;
        end else begin
          result_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_MISMATCH_LOG) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("unexpected sample=%0d column=%0d out_row=%0d last=%0b",
                               result.sample, result.column, result.out_row, result.last));
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (result.sample !== want.sample || result.column !== want.column ||
            result.out_row !== want.out_row || result.last !== want.last) begin
          note_failure($sformatf(
              "expected sample=%0d column=%0d out_row=%0d last=%0b, got %0d %0d %0d %0b",
              want.sample, want.column, want.out_row, want.last,
              result.sample, result.column, result.out_row, result.last));
        end
      end
    end
  end

  function automatic int block_size(input int lg);
    if (lg < iap_pkg::LOG2_MIN) lg = iap_pkg::LOG2_MIN;
    if (lg > iap_pkg::LOG2_MAX) lg = iap_pkg::LOG2_MAX;
    return 1 << lg;
  endfunction

  function automatic int store_rd(input bit from_left, input int idx);
    if (idx < 0 || idx >= REF_DEPTH) return 0;
    return from_left ? int'(left_copy[idx]) : int'(above_copy[idx]);
  endfunction

  // Main reference; indices below zero are projected onto the side reference.
  function automatic int main_rd(input bit ver, input int idx, input int inv);
    if (idx >= 0) return store_rd(!ver, idx);
    return store_rd(ver, (iap_pkg::INV_ROUND + (-idx) * inv) >>> 8);
  endfunction

  function automatic void predict_row(input iap_pkg::item_t it);
    int n, row, dir, angle, absa, inv, bd, maxv, k, l, v, pos, fr, i;
    bit ver;
    iap_pkg::result_t r;
    n = block_size(it.block_log2);
    row = it.row;
    if (row >= n) return;
    dir = it.pred_dir;
    if (dir < iap_pkg::DIR_MIN) dir = iap_pkg::DIR_MIN;
    if (dir > iap_pkg::DIR_MAX) dir = iap_pkg::DIR_MAX;
    ver = (dir >= iap_pkg::DIR_VER_MIN);
    angle = ver ? dir - iap_pkg::DIR_VER_CENTER : iap_pkg::DIR_HOR_CENTER - dir;
    absa = (angle < 0) ? -angle : angle;
    inv = INV_TABLE[absa];
    angle = (angle < 0) ? -ANGLE_TABLE[absa] : ANGLE_TABLE[absa];
    bd = depth_reg;
    if (bd < iap_pkg::BD_MIN) bd = iap_pkg::BD_MIN;
    if (bd > iap_pkg::BD_MAX) bd = iap_pkg::BD_MAX;
    maxv = (1 << bd) - 1;
    rows_sent++;
    for (int c = 0; c < n; c++) begin
      k = ver ? row : c;
      l = ver ? c : row;
      if (angle == 0) begin
        v = main_rd(ver, l + 1, inv);
        if (it.edge_filter && l == 0) begin
          // Arithmetic shift gives the floor of half the side gradient.
          v += (store_rd(ver, k + 1) - store_rd(ver, 0)) >>> 1;
          if (v < 0) v = 0;
          if (v > maxv) v = maxv;
        end
      end else begin
        pos = (k + 1) * angle;
        fr = pos & 31;
        i = l + (pos >>> 5) + 1;
        if (fr != 0) begin
          v = ((32 - fr) * main_rd(ver, i, inv) + fr * main_rd(ver, i + 1, inv)
               + iap_pkg::INTERP_ROUND) >>> 5;
        end else begin
          v = main_rd(ver, i, inv);
        end
      end
      r.sample = 12'(v);
      r.column = 5'(c);
      r.out_row = 5'(row);
      r.last = (c == n - 1);
      pending_samples.push_back(r);
    end
  endfunction

  function automatic void apply_item(input iap_pkg::item_t it);
    case (it.mode)
      iap_pkg::MODE_LOAD_ABOVE: begin
        if (it.ref_index < REF_DEPTH) above_copy[it.ref_index] = it.ref_sample;
        loads_done++;
      end
      iap_pkg::MODE_LOAD_LEFT: begin
        if (it.ref_index < REF_DEPTH) left_copy[it.ref_index] = it.ref_sample;
        loads_done++;
      end
      iap_pkg::MODE_PREDICT: predict_row(it);
      default: ;
    endcase
  endfunction

  function automatic iap_pkg::item_t rand_fields();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[35:0];
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int rand_dir();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? iap_pkg::DIR_VER_CENTER : iap_pkg::DIR_HOR_CENTER;
    end
    return $urandom_range(iap_pkg::DIR_MIN, iap_pkg::DIR_MAX);
  endfunction

  function automatic iap_pkg::item_t make_load(input bit to_left, input int idx,
                                               input int val);
    iap_pkg::item_t it;
    it = rand_fields();
    it.mode = to_left ? iap_pkg::MODE_LOAD_LEFT : iap_pkg::MODE_LOAD_ABOVE;
    it.ref_index = 7'(idx);
    it.ref_sample = 12'(val);
    return it;
  endfunction

  function automatic iap_pkg::item_t make_request(input int lg, input int dir, input bit filt,
                                                  input int row);
    iap_pkg::item_t it;
    it = rand_fields();
    it.mode = iap_pkg::MODE_PREDICT;
    it.block_log2 = 3'(lg);
    it.pred_dir = 6'(dir);
    it.edge_filter = filt;
    it.row = 5'(row);
    return it;
  endfunction

  task automatic send_item(input iap_pkg::item_t it);
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    apply_item(it);
  endtask

  // Sends one item, then idles for a random gap when the current burst runs out.
  task automatic issue(input iap_pkg::item_t it);
    int gap;
    send_item(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds off until every expected sample has arrived and the pipeline has emptied.
  task automatic quiesce();
    item_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_depth(input int val);
    cfg_data <= 4'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    depth_reg = val;
    depth_writes++;
  endtask

  // Every entry of both stores is written so that later reads are always defined.
  task automatic test_reference_fill();
    for (int idx = 0; idx < REF_DEPTH; idx++) begin
      issue(make_load(1'b0, idx, rand_sample()));
      issue(make_load(1'b1, idx, rand_sample()));
    end
  endtask

  task automatic test_directed_cases();
    iap_pkg::item_t it;
    issue(make_load(1'b0, 64, 4095));
    issue(make_load(1'b1, 64, 0));
    issue(make_load(1'b0, 0, 0));
    issue(make_load(1'b1, 0, 4095));
    // A load past the end of the store must leave both stores untouched.
    issue(make_load(1'b0, 127, 4095));
    it = rand_fields();
    it.mode = MODE_UNUSED;
    issue(it);
    issue(make_request(2, 2, 1'b0, 0));
    issue(make_request(5, 34, 1'b0, 31));
    issue(make_request(5, 2, 1'b1, 31));
    issue(make_request(5, 18, 1'b0, 31));
    issue(make_request(5, 11, 1'b0, 0));
    issue(make_request(5, 25, 1'b0, 17));
    issue(make_request(3, 26, 1'b1, 5));
    issue(make_request(3, 10, 1'b1, 2));
    issue(make_request(3, 26, 1'b0, 0));
    issue(make_request(5, 10, 1'b1, 31));
    issue(make_request(0, 0, 1'b0, 3));
    issue(make_request(7, 63, 1'b1, 0));
    issue(make_request(1, 1, 1'b0, 1));
    issue(make_request(6, 35, 1'b0, 30));
    // The first two rows here lie at or beyond the block size and produce nothing.
    issue(make_request(2, 26, 1'b0, 4));
    issue(make_request(4, 10, 1'b0, 31));
    issue(make_request(2, 18, 1'b1, 0));
  endtask

  // Pure vertical and horizontal rows with large side gradients push the
  // filtered column past both ends of the range at each bit depth.
  task automatic test_edge_filter_clip();
    int depths [4] = '{0, 8, 12, 15};
    foreach (depths[d]) begin
      quiesce();
      write_depth(depths[d]);
      issue(make_load(1'b0, 1, 4095));
      issue(make_load(1'b1, 1, 4095));
      issue(make_load(1'b1, 0, 0));
      issue(make_request(3, 26, 1'b1, 0));
      issue(make_request(5, 10, 1'b1, 0));
      issue(make_load(1'b0, 1, 0));
      issue(make_load(1'b1, 1, 0));
      issue(make_load(1'b1, 0, 4095));
      issue(make_load(1'b0, 0, 4095));
      issue(make_request(3, 26, 1'b1, 0));
      issue(make_request(2, 10, 1'b1, 0));
      issue(make_request(4, 10, 1'b1, 5));
    end
  endtask

  task automatic test_random_traffic();
    int first, lg, n, dir, reps;
    bit filt;
    iap_pkg::item_t it;
    for (int chunk = 0; chunk < 4; chunk++) begin
      quiesce();
      write_depth($urandom_range(0, 15));
      first = items_sent;
      while (items_sent - first < 50) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // A few reference updates followed by rows of one block.
            reps = $urandom_range(1, 4);
            for (int j = 0; j < reps; j++) begin
              issue(make_load($urandom_range(0, 1), $urandom_range(0, REF_DEPTH - 1),
                              rand_sample()));
            end
            lg = $urandom_range(0, 9);
            lg = (lg < 4) ? 2 : (lg < 7) ? 3 : (lg < 9) ? 4 : 5;
            n = block_size(lg);
            reps = $urandom_range(2, 6);
            for (int j = 0; j < reps; j++) begin
              issue(make_request(lg, rand_dir(), $urandom_range(0, 1), $urandom_range(0, n - 1)));
            end
          end
          6: begin
            // Fresh references for a small block, then a few rows.
            lg = $urandom_range(2, 3);
            n = block_size(lg);
            for (int idx = 0; idx <= 2 * n; idx++) begin
              issue(make_load(1'b0, idx, rand_sample()));
              issue(make_load(1'b1, idx, rand_sample()));
            end
            for (int j = 0; j < 3; j++) begin
              issue(make_request(lg, rand_dir(), $urandom_range(0, 1), $urandom_range(0, n - 1)));
            end
          end
          7, 8: begin
            case ($urandom_range(0, 3))
              0: begin
                it = rand_fields();
                it.mode = MODE_UNUSED;
                issue(it);
              end
              1: issue(make_load($urandom_range(0, 1), $urandom_range(REF_DEPTH, 127),
                                 rand_sample()));
              2: begin
                lg = $urandom_range(2, 4);
                n = block_size(lg);
                issue(make_request(lg, rand_dir(), $urandom_range(0, 1), $urandom_range(n, 31)));
              end
              default: begin
                lg = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(6, 7);
                dir = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(35, 63);
                n = block_size(lg);
                issue(make_request(lg, dir, $urandom_range(0, 1), $urandom_range(0, n - 1)));
              end
            endcase
          end
          default: begin
            // Every row of one small block in order.
            lg = $urandom_range(2, 3);
            n = block_size(lg);
            dir = rand_dir();
            filt = $urandom_range(0, 1);
            for (int r = 0; r < n; r++) issue(make_request(lg, dir, filt, r));
          end
        endcase
      end
    end
  endtask

  task automatic finish_run();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_samples.size() != 0) begin
      note_failure($sformatf("%0d expected samples never arrived", pending_samples.size()));
    end
    $display("Covered %0d row requests and %0d reference loads across %0d bit depth writes.",
             rows_sent, loads_done, depth_writes);
    $display("Checked %0d samples; %0d mismatches.", samples_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reference_fill();
    test_directed_cases();
    test_edge_filter_clip();
    test_random_traffic();
    finish_run();
  end

endmodule
